// ===== hw/rtl/sdr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdr_pkg: shared types and constants for the sd spi block read sequencer
// Phase codes, field widths, protocol bytes and the state and result structs.
// ----------------------------------------------------------------------------
package sdr_pkg;

  // field and counter widths
  localparam int unsigned SectorW   = 23;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned ByteCntW  = 10;
  localparam int unsigned PollCntW  = 3;
  localparam int unsigned RetryW    = 16;
  localparam int unsigned AddrShift = 9;

  // parameter defaults
  localparam int unsigned BlockBytesDef    = 512;
  localparam int unsigned ResponsePollsDef = 8;

  // register reset values
  localparam logic [RetryW-1:0] TokenRetryRst = 16'hFFFF;
  localparam logic [ByteW-1:0]  FillerCntRst  = 8'd20;

  // register indexes
  localparam logic RegTokenRetry = 1'b0;
  localparam logic RegFillerCnt  = 1'b1;

  // protocol bytes
  localparam logic [ByteW-1:0] IdleByte   = 8'hFF;
  localparam logic [ByteW-1:0] StartToken = 8'hFE;
  localparam logic [ByteW-1:0] CmdRead    = 8'h51;

  // input operations
  localparam logic OpStart    = 1'b0;
  localparam logic OpExchange = 1'b1;

  // sequencer phases
  localparam logic [3:0] PhIdle  = 4'd0;
  localparam logic [3:0] PhFill  = 4'd1;
  localparam logic [3:0] PhCmd   = 4'd2;
  localparam logic [3:0] PhArg   = 4'd3;
  localparam logic [3:0] PhCrc   = 4'd4;
  localparam logic [3:0] PhGap   = 4'd5;
  localparam logic [3:0] PhR1    = 4'd6;
  localparam logic [3:0] PhToken = 4'd7;
  localparam logic [3:0] PhData  = 4'd8;
  localparam logic [3:0] PhSkip  = 4'd9;

  // output bus layout, lowest bit up
  localparam int unsigned OutTxSendBit = 0;
  localparam int unsigned OutSelectBit = 9;
  localparam int unsigned OutDoneBit   = 18;
  localparam int unsigned OutStatusBit = 19;

  typedef struct packed {
    logic [3:0]          phase;
    logic [ByteCntW-1:0] byte_cnt;
    logic [PollCntW-1:0] poll_cnt;
    logic [RetryW-1:0]   retries_left;
    logic [ByteW-1:0]    first_resp;
    logic [AddrW-1:0]    byte_addr;
  } sdr_state_t;

  typedef struct packed {
    logic             tx_send;
    logic [ByteW-1:0] tx_byte;
    logic             card_select;
    logic             data_valid;
    logic [ByteW-1:0] data_byte;
    logic             last_data;
    logic             done_res;
    logic             status;
  } sdr_result_t;

  typedef struct packed {
    logic [RetryW-1:0] token_retry_limit;
    logic [ByteW-1:0]  filler_byte_count;
  } sdr_cfg_t;

  localparam sdr_state_t StateRst = '{
    phase:        PhIdle,
    byte_cnt:     '0,
    poll_cnt:     '0,
    retries_left: '0,
    first_resp:   IdleByte,
    byte_addr:    '0
  };

endpackage

// ===== hw/rtl/sdr_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdr_cfg: configuration register file
// Holds the token retry limit and the filler byte count behind an apb port.
// ----------------------------------------------------------------------------
module sdr_cfg
  import sdr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output sdr_cfg_t    cfg_o
);

  logic [RetryW-1:0] retry_q;
  logic [ByteW-1:0]  filler_q;
  logic              wr_en;
  logic              reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[2];

  // register writes on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_q  <= TokenRetryRst;
      filler_q <= FillerCntRst;
    end else if (wr_en) begin
      case (reg_idx)
        RegTokenRetry: retry_q  <= pwdata[RetryW-1:0];
        RegFillerCnt:  filler_q <= pwdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      RegTokenRetry: prdata = {{(32-RetryW){1'b0}}, retry_q};
      RegFillerCnt:  prdata = {{(32-ByteW){1'b0}}, filler_q};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.token_retry_limit = retry_q;
  assign cfg_o.filler_byte_count = filler_q;

endmodule

// ===== hw/rtl/sdr_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdr_step: next-state and result logic of the read sequencer
// Takes one registered input item and the current state, gives the next state
// and the result item for that exchange.
// ----------------------------------------------------------------------------
module sdr_step
  import sdr_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES    = BlockBytesDef,
  parameter int unsigned RESPONSE_POLLS = ResponsePollsDef
) (
  input  logic               op_i,
  input  logic [SectorW-1:0] sector_i,
  input  logic [ByteW-1:0]   rx_byte_i,
  input  sdr_cfg_t           cfg_i,
  input  sdr_state_t         state_i,
  output sdr_state_t         state_o,
  output sdr_result_t        result_o
);

  localparam logic [ByteCntW:0] BlockLim = (ByteCntW+1)'(BLOCK_BYTES);
  localparam logic [PollCntW:0] PollLim  = (PollCntW+1)'(RESPONSE_POLLS);

  logic [ByteCntW-1:0] cnt_dec;
  logic [ByteCntW-1:0] cnt_inc;
  logic [PollCntW:0]   poll_inc;
  logic                poll_end;
  logic                rx_idle;
  logic [RetryW-1:0]   retry_dec;
  logic [RetryW-1:0]   retry_init;
  logic [ByteW-1:0]    arg_byte;
  logic                data_last;

  assign cnt_dec    = state_i.byte_cnt - 1'b1;
  assign cnt_inc    = state_i.byte_cnt + 1'b1;
  assign poll_inc   = {1'b0, state_i.poll_cnt} + 1'b1;
  assign poll_end   = poll_inc >= PollLim;
  assign rx_idle    = rx_byte_i == IdleByte;
  assign retry_dec  = state_i.retries_left - 1'b1;
  assign retry_init = (cfg_i.token_retry_limit != '0) ? cfg_i.token_retry_limit
                                                      : RetryW'(1);
  assign data_last  = ({1'b0, state_i.byte_cnt} + 1'b1) >= BlockLim;

  // big-endian argument byte that follows the current one
  always_comb begin
    case (cnt_inc[1:0])
      2'd1:    arg_byte = state_i.byte_addr[23:16];
      2'd2:    arg_byte = state_i.byte_addr[15:8];
      2'd3:    arg_byte = state_i.byte_addr[7:0];
      default: arg_byte = state_i.byte_addr[31:24];
    endcase
  end

  // phase sequencing
  always_comb begin
    state_o  = state_i;
    result_o = '{tx_send: 1'b1, tx_byte: IdleByte, card_select: 1'b1,
                 default: 1'b0};
    if (op_i == OpStart) begin
      state_o.byte_addr    = {sector_i, {AddrShift{1'b0}}};
      state_o.poll_cnt     = '0;
      state_o.retries_left = '0;
      state_o.first_resp   = IdleByte;
      if (cfg_i.filler_byte_count != '0) begin
        state_o.phase    = PhFill;
        state_o.byte_cnt = ByteCntW'(cfg_i.filler_byte_count);
      end else begin
        state_o.phase    = PhCmd;
        state_o.byte_cnt = '0;
        result_o.tx_byte = CmdRead;
      end
    end else begin
      case (state_i.phase)
        PhFill: begin
          state_o.byte_cnt = cnt_dec;
          if (cnt_dec == '0) begin
            state_o.phase    = PhCmd;
            result_o.tx_byte = CmdRead;
          end
        end
        PhCmd: begin
          state_o.phase    = PhArg;
          state_o.byte_cnt = '0;
          result_o.tx_byte = state_i.byte_addr[31:24];
        end
        PhArg: begin
          if (cnt_inc < ByteCntW'(4)) begin
            state_o.byte_cnt = cnt_inc;
            result_o.tx_byte = arg_byte;
          end else begin
            state_o.phase    = PhCrc;
            state_o.byte_cnt = '0;
          end
        end
        PhCrc: state_o.phase = PhGap;
        PhGap: begin
          state_o.phase    = PhR1;
          state_o.poll_cnt = '0;
        end
        PhR1: begin
          if (!rx_idle || poll_end) begin
            state_o.first_resp   = rx_byte_i;
            state_o.phase        = PhToken;
            state_o.poll_cnt     = '0;
            state_o.retries_left = retry_init;
          end else begin
            state_o.poll_cnt = poll_inc[PollCntW-1:0];
          end
        end
        PhToken: begin
          // search ends on any non-idle byte or when the rounds run out
          if (!rx_idle) begin
            if (state_i.first_resp != '0 || rx_byte_i != StartToken) begin
              state_o.phase = PhIdle;
              result_o      = '{tx_byte: IdleByte, done_res: 1'b1, status: 1'b1,
                                default: 1'b0};
            end else begin
              state_o.phase    = PhData;
              state_o.byte_cnt = '0;
            end
          end else if (poll_end) begin
            state_o.poll_cnt     = '0;
            state_o.retries_left = retry_dec;
            if (retry_dec == '0) begin
              state_o.phase = PhIdle;
              result_o      = '{tx_byte: IdleByte, done_res: 1'b1, status: 1'b1,
                                default: 1'b0};
            end
          end else begin
            state_o.poll_cnt = poll_inc[PollCntW-1:0];
          end
        end
        PhData: begin
          result_o.data_valid = 1'b1;
          result_o.data_byte  = rx_byte_i;
          result_o.last_data  = data_last;
          if (data_last) begin
            state_o.phase    = PhSkip;
            state_o.byte_cnt = '0;
          end else begin
            state_o.byte_cnt = cnt_inc;
          end
        end
        PhSkip: begin
          if (state_i.byte_cnt == '0) begin
            state_o.byte_cnt = ByteCntW'(1);
          end else begin
            state_o.phase    = PhIdle;
            state_o.byte_cnt = '0;
            result_o         = '{tx_byte: IdleByte, done_res: 1'b1, default: 1'b0};
          end
        end
        default: begin
          // exchange reports while idle are ignored
          state_o.phase = PhIdle;
          result_o      = '{tx_byte: IdleByte, default: 1'b0};
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/sd_spi_block_read.sv =====
`timescale 1ns / 1ps
// Path: an accepted input transfer is held in the input register, then passes
//   through the sequencer logic into the result register.
// Throughput: one item per cycle while the result stream is not stalled.
// Reset: asynchronous, active low; sequencer idle, counters cleared, token
//   retry limit 65535 and filler count 20, both output and input stages empty.
// ----------------------------------------------------------------------------
// sd_spi_block_read: host-side sd card single block read sequencer, spi mode
// Drives filler bytes, the read command frame, response and token polling,
// then streams the sector data bytes and reports done and status.
// ----------------------------------------------------------------------------
module sd_spi_block_read
  import sdr_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES    = BlockBytesDef,
  parameter int unsigned RESPONSE_POLLS = ResponsePollsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // sector[22:0], rx_byte[30:23], zero pad
  input  logic        s_axis_tuser,  // operation
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // tx_send[0], tx_byte[8:1], card_select[9],
                                     // data_byte[17:10], done_res[18],
                                     // status[19], zero pad
  output logic        m_axis_tuser,  // data_valid
  output logic        m_axis_tlast,  // last_data
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sdr_cfg_t           cfg;
  logic               in_vld_q;
  logic               in_op_q;
  logic [SectorW-1:0] in_sector_q;
  logic [ByteW-1:0]   in_rx_q;
  logic               out_vld_q;
  sdr_result_t        out_res_q;
  sdr_state_t         state_q;
  sdr_state_t         state_d;
  sdr_result_t        res_d;
  logic               out_free;
  logic               step_fire;

  sdr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshake between the two register stages
  assign out_free      = !out_vld_q || m_axis_tready;
  assign step_fire     = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q     <= s_axis_tuser;
      in_sector_q <= s_axis_tdata[SectorW-1:0];
      in_rx_q     <= s_axis_tdata[SectorW+ByteW-1:SectorW];
    end
  end

  sdr_step #(
    .BLOCK_BYTES    (BLOCK_BYTES),
    .RESPONSE_POLLS (RESPONSE_POLLS)
  ) u_step (
    .op_i      (in_op_q),
    .sector_i  (in_sector_q),
    .rx_byte_i (in_rx_q),
    .cfg_i     (cfg),
    .state_i   (state_q),
    .state_o   (state_d),
    .result_o  (res_d)
  );

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateRst;
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, out_res_q.status, out_res_q.done_res,
                          out_res_q.data_byte, out_res_q.card_select,
                          out_res_q.tx_byte, out_res_q.tx_send};
  assign m_axis_tuser  = out_res_q.data_valid;
  assign m_axis_tlast  = out_res_q.last_data;

endmodule

// ===== hw/rtl/sdr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdr_checker: port-level checks for the block read sequencer
// Watches the result stream for consistent select, done and data flags.
// ----------------------------------------------------------------------------
module sdr_checker
  import sdr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // a data byte comes only with the card selected and a further exchange
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[OutSelectBit] && m_axis_tdata[OutTxSendBit])
    else $error("data byte without card select");

  // the last data mark rides on a data byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("last mark without data byte");

  // completion releases the card and an error flag needs completion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[OutDoneBit] || m_axis_tdata[OutStatusBit]) |->
      m_axis_tdata[OutDoneBit] && !m_axis_tdata[OutSelectBit] &&
      !m_axis_tdata[OutTxSendBit])
    else $error("done result keeps card selected");

endmodule

bind sd_spi_block_read sdr_checker u_sdr_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sd spi block read sequencer
// Drives start and exchange transfers with random gaps and back-pressure and
// predicts every result from a cycle-free model of the sequencer. It covers
// whole sector reads, bad and missing R1 bytes, bad tokens, token timeouts,
// restarts and stray exchanges, under several register settings.
// ----------------------------------------------------------------------------
module tb;
  import sdr_pkg::*;

  localparam int unsigned BlockBytes = BlockBytesDef;
  localparam int unsigned RespPolls  = ResponsePollsDef;
  localparam int unsigned NumPhases  = 5;
  localparam int unsigned PhaseItems = 60;
  localparam int unsigned HoldCycles = 300;
  localparam logic [ByteW-1:0] R1Ok  = 8'h00;

  typedef enum int {SeqGood, SeqBadR1, SeqBadToken, SeqTimeout, SeqAbort, SeqNoise} seq_kind_e;

  // --------------------------------------------------------------------------
  // sequencer predictor and store of expected results
  // --------------------------------------------------------------------------
  class sdr_scoreboard;
    sdr_cfg_t    cfg;
    sdr_state_t  st;
    sdr_result_t expected_q[$];
    int unsigned n_items, n_checked, n_mismatch, n_unexpected, n_reported;
    int unsigned n_data, n_reads_ok, n_reads_failed;

    function new();
      cfg.token_retry_limit = TokenRetryRst;
      cfg.filler_byte_count = FillerCntRst;
      st = StateRst;
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == RegTokenRetry) cfg.token_retry_limit = value[RetryW-1:0];
      else cfg.filler_byte_count = value[ByteW-1:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int unsigned errors();
      return n_mismatch + n_unexpected + expected_q.size();
    endfunction

    // one accepted input transfer moves the sequencer by one step
    function void note_input(logic op, logic [SectorW-1:0] sec, logic [ByteW-1:0] rx);
      sdr_result_t r;
      logic fail, found, last;
      r = '0;
      r.tx_send = 1'b1;
      r.tx_byte = IdleByte;
      r.card_select = 1'b1;
      fail = 1'b0;
      found = 1'b0;
      last = 1'b0;
      n_items++;
      if (op == OpStart) begin
        st.byte_addr = AddrW'(sec) << AddrShift;
        st.poll_cnt = '0;
        st.retries_left = '0;
        st.first_resp = IdleByte;
        if (cfg.filler_byte_count != '0) begin
          st.phase = PhFill;
          st.byte_cnt = ByteCntW'(cfg.filler_byte_count);
        end else begin
          st.phase = PhCmd;
          st.byte_cnt = '0;
          r.tx_byte = CmdRead;
        end
      end else begin
        case (st.phase)
          PhFill: begin
            st.byte_cnt = st.byte_cnt - 1'b1;
            if (st.byte_cnt == '0) begin
              st.phase = PhCmd;
              r.tx_byte = CmdRead;
            end
          end
          PhCmd: begin
            st.phase = PhArg;
            st.byte_cnt = '0;
            r.tx_byte = st.byte_addr[31:24];
          end
          // argument goes out most significant byte first
          PhArg: begin
            st.byte_cnt = st.byte_cnt + 1'b1;
            if (st.byte_cnt < 4) begin
              r.tx_byte = ByteW'(st.byte_addr >> (8 * (3 - int'(st.byte_cnt))));
            end else begin
              st.phase = PhCrc;
              st.byte_cnt = '0;
            end
          end
          PhCrc: st.phase = PhGap;
          PhGap: begin
            st.phase = PhR1;
            st.poll_cnt = '0;
          end
          // r1 ends on a non-idle byte or the last poll
          PhR1: begin
            if (rx != IdleByte || int'(st.poll_cnt) + 1 >= RespPolls) begin
              st.first_resp = rx;
              st.phase = PhToken;
              st.poll_cnt = '0;
              st.retries_left = (cfg.token_retry_limit != '0) ? cfg.token_retry_limit
                                                               : RetryW'(1);
            end else begin
              st.poll_cnt = st.poll_cnt + 1'b1;
            end
          end
          // token search in rounds of response polls
          PhToken: begin
            if (rx != IdleByte) begin
              found = 1'b1;
              fail = (st.first_resp != R1Ok) || (rx != StartToken);
            end else if (int'(st.poll_cnt) + 1 >= RespPolls) begin
              st.poll_cnt = '0;
              st.retries_left = st.retries_left - 1'b1;
              if (st.retries_left == '0) fail = 1'b1;
            end else begin
              st.poll_cnt = st.poll_cnt + 1'b1;
            end
            if (fail) begin
              st.phase = PhIdle;
              r.tx_send = 1'b0;
              r.card_select = 1'b0;
              r.done_res = 1'b1;
              r.status = 1'b1;
              n_reads_failed++;
            end else if (found) begin
              st.phase = PhData;
              st.byte_cnt = '0;
            end
          end
          PhData: begin
            last = (int'(st.byte_cnt) + 1 >= BlockBytes);
            if (last) begin
              st.phase = PhSkip;
              st.byte_cnt = '0;
            end else begin
              st.byte_cnt = st.byte_cnt + 1'b1;
            end
            r.data_valid = 1'b1;
            r.data_byte = rx;
            r.last_data = last;
            n_data++;
          end
          // two crc bytes dropped, then select released
          PhSkip: begin
            if (st.byte_cnt == '0) begin
              st.byte_cnt = ByteCntW'(1);
            end else begin
              st.phase = PhIdle;
              st.byte_cnt = '0;
              r.tx_send = 1'b0;
              r.card_select = 1'b0;
              r.done_res = 1'b1;
              n_reads_ok++;
            end
          end
          default: begin
            st.phase = PhIdle;
            r.tx_send = 1'b0;
            r.card_select = 1'b0;
          end
        endcase
      end
      expected_q.push_back(r);
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(logic [23:0] data, logic user, logic last);
      sdr_result_t a, e;
      string diff;
      a.tx_send     = data[OutTxSendBit];
      a.tx_byte     = data[OutTxSendBit+1 +: ByteW];
      a.card_select = data[OutSelectBit];
      a.data_byte   = data[OutSelectBit+1 +: ByteW];
      a.done_res    = data[OutDoneBit];
      a.status      = data[OutStatusBit];
      a.data_valid  = user;
      a.last_data   = last;
      if (expected_q.size() == 0) begin
        n_unexpected++;
        if (n_reported++ < 10) $display("tb: result with none expected, tdata %h", data);
        return;
      end
      e = expected_q.pop_front();
      n_checked++;
      diff = "";
      if (a.tx_send !== e.tx_send)
        diff = {diff, $sformatf(" tx_send %0d/%0d", e.tx_send, a.tx_send)};
      if (a.tx_byte !== e.tx_byte)
        diff = {diff, $sformatf(" tx_byte %h/%h", e.tx_byte, a.tx_byte)};
      if (a.card_select !== e.card_select)
        diff = {diff, $sformatf(" card_select %0d/%0d", e.card_select, a.card_select)};
      if (a.data_valid !== e.data_valid)
        diff = {diff, $sformatf(" data_valid %0d/%0d", e.data_valid, a.data_valid)};
      if (a.data_byte !== e.data_byte)
        diff = {diff, $sformatf(" data_byte %h/%h", e.data_byte, a.data_byte)};
      if (a.last_data !== e.last_data)
        diff = {diff, $sformatf(" last_data %0d/%0d", e.last_data, a.last_data)};
      if (a.done_res !== e.done_res)
        diff = {diff, $sformatf(" done_res %0d/%0d", e.done_res, a.done_res)};
      if (a.status !== e.status)
        diff = {diff, $sformatf(" status %0d/%0d", e.status, a.status)};
      if (diff != "") begin
        n_mismatch++;
        if (n_reported++ < 10)
          $display("tb: result %0d mismatch (expected/actual):%s", n_checked, diff);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports
  // --------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // sector[22:0], rx_byte[30:23], zero pad
  logic        s_axis_tuser = 1'b0;  // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;  // tx_send[0], tx_byte[8:1], card_select[9],
                              // data_byte[17:10], done_res[18], status[19]
  logic        m_axis_tuser;  // data_valid
  logic        m_axis_tlast;  // last_data
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sdr_scoreboard sb;
  bit          hold_req = 1'b0;
  bit          sender_quiet = 1'b0;
  int          abort_after = -1;
  int unsigned seq_items;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sd_spi_block_read #(
    .BLOCK_BYTES   (BlockBytes),
    .RESPONSE_POLLS(RespPolls)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // --------------------------------------------------------------------------
  // monitors
  // --------------------------------------------------------------------------
  // accepted input transfer
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_input(s_axis_tuser, s_axis_tdata[SectorW-1:0],
                    s_axis_tdata[SectorW +: ByteW]);
  end

  // accepted result transfer
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SectorW-1:0] rand_sector();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return SectorW'($urandom);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int burst, gap;
    @(posedge clk_i);
    forever begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
      m_axis_tready <= 1'b1;
      repeat (burst) @(posedge clk_i);
      gap = pick_gap();
      if (hold_req) begin
        gap = HoldCycles;
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // apb write: setup then access
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk_i);
  endtask

  // one input transfer; valid stays high across back-to-back transfers
  task automatic send_item(input logic op, input logic [SectorW-1:0] sec,
                           input logic [ByteW-1:0] rx);
    int gap;
    gap = sender_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {1'b0, rx, sec};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // exchange report; swallowed once an abort point is reached
  task automatic exch(input logic [ByteW-1:0] rx);
    if (abort_after == 0) return;
    if (abort_after > 0) abort_after--;
    send_item(OpExchange, SectorW'($urandom), rx);
    seq_items++;
  endtask

  // sender pauses until every result is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // one read as the card would answer it, shaped by the kind
  task automatic run_read(input seq_kind_e kind);
    int polls, n_ff, fill;
    fill = int'(sb.cfg.filler_byte_count);
    polls = RespPolls * ((sb.cfg.token_retry_limit == '0) ? 1 : int'(sb.cfg.token_retry_limit));
    if (kind == SeqTimeout && polls > 64) kind = SeqBadToken;
    if (kind == SeqAbort)
      abort_after = ($urandom_range(0, 2) == 0) ? $urandom_range(1, fill + 40 + BlockBytes)
                                                : $urandom_range(1, fill + 37);
    send_item(OpStart, rand_sector(), ByteW'($urandom));
    seq_items++;
    // filler and command frame: received bytes are don't-care
    repeat (fill + 7) exch(ByteW'($urandom));
    // r1: late, missing or bad
    if (kind == SeqBadR1 && $urandom_range(0, 2) == 0) begin
      repeat (RespPolls) exch(IdleByte);
    end else begin
      repeat ($urandom_range(0, RespPolls - 1)) exch(IdleByte);
      exch(kind == SeqBadR1 ? ByteW'($urandom_range(1, 254)) : R1Ok);
    end
    // start token
    if (kind == SeqTimeout) begin
      repeat (polls) exch(IdleByte);
    end else begin
      n_ff = $urandom_range(0, (polls - 1 < 24) ? polls - 1 : 24);
      repeat (n_ff) exch(IdleByte);
      if (kind == SeqBadToken || (kind == SeqBadR1 && $urandom_range(0, 1) == 0))
        exch(ByteW'($urandom_range(0, 253)));
      else
        exch(StartToken);
    end
    // sector data and crc
    if (kind == SeqGood || kind == SeqAbort)
      repeat (BlockBytes + 2) exch(ByteW'($urandom));
    abort_after = -1;
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stim
    int unsigned limits[NumPhases];
    int unsigned fills[NumPhases];
    int unsigned r;
    seq_kind_e kind;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero retry limit and zero filler count
    write_reg(RegTokenRetry, 32'd0);
    write_reg(RegFillerCnt, 32'd0);
    // exchange with nothing running is ignored
    send_item(OpExchange, '1, IdleByte);
    // top sector, restarted on sector zero after three bytes
    send_item(OpStart, '1, 8'h00);
    repeat (3) send_item(OpExchange, '0, 8'h00);
    send_item(OpStart, '0, IdleByte);
    // command frame, then r1 on the first poll
    for (int i = 0; i < 7; i++) send_item(OpExchange, '1, (i % 2) ? IdleByte : 8'h00);
    send_item(OpExchange, '0, R1Ok);
    // one round without the token times out
    repeat (RespPolls) send_item(OpExchange, '1, IdleByte);
    send_item(OpExchange, '0, 8'h5A);
    wait_drained();

    // register settings per random phase
    limits[0] = 32'hFFFF;  fills[0] = 20;
    limits[1] = 1;         fills[1] = 255;
    limits[2] = 2;         fills[2] = 1;
    limits[3] = $urandom_range(1, 4);      fills[3] = $urandom_range(0, 6);
    limits[4] = $urandom_range(1, 65535);  fills[4] = $urandom_range(0, 31);

    for (int p = 0; p < NumPhases; p++) begin
      write_reg(RegTokenRetry, limits[p]);
      write_reg(RegFillerCnt, fills[p]);
      // long receiver hold-off while the sender keeps going
      if (p == 1) hold_req = 1'b1;
      seq_items = 0;
      if (p == 0) run_read(SeqGood);
      while (seq_items < PhaseItems) begin
        sender_quiet = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 10) kind = SeqGood;
        else if (r < 30) kind = SeqBadR1;
        else if (r < 50) kind = SeqBadToken;
        else if (r < 62) kind = SeqTimeout;
        else if (r < 88) kind = SeqAbort;
        else kind = SeqNoise;
        if (kind == SeqNoise)
          repeat ($urandom_range(1, 3))
            send_item(($urandom_range(0, 3) == 0) ? OpStart : OpExchange,
                      rand_sector(), ByteW'($urandom));
        else
          run_read(kind);
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
      sender_quiet = 1'b0;
      // leave the sequencer idle before the next register writes
      if (sb.st.phase != PhIdle) run_read(SeqBadToken);
      wait_drained();
    end

    $display("tb: %0d transfers in, %0d results checked; %0d reads done, %0d failed",
             sb.n_items, sb.n_checked, sb.n_reads_ok, sb.n_reads_failed);
    $display("tb: %0d sector bytes, %0d mismatches, %0d unexpected, %0d missing",
             sb.n_data, sb.n_mismatch, sb.n_unexpected, sb.pending());
    if (sb.errors() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sdr_pkg.sv
hw/rtl/sdr_cfg.sv
hw/rtl/sdr_step.sv
hw/rtl/sd_spi_block_read.sv
hw/rtl/sdr_checker.sv
tb/tb.sv
